// ===== rtl/rsi_pkg.sv =====
// Shared constants for the ray/sphere intersection block.
// No dependencies; used by ray_sphere_intersect.
package rsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RADIUS   = 2'd3;

  // hit count codes
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

endpackage

// ===== rtl/ray_sphere_intersect.sv =====
// Ray/sphere intersection, fully pipelined, one ray word per cycle while the output is not stalled.
// 5*COORD_WIDTH+20 register stages: 7 setup, a root load stage plus one per root bit,
//   3 forming n*D, a divider load stage plus one per quotient bit, 2 rounding, output reg.
// Throughput: one word per cycle; the whole pipe advances when the output register is free.
// Reset (rst, synchronous): clears valid bits; center = 0, radius = 1.0.
// Depends on rsi_pkg.
module ray_sphere_intersect #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // origin x,y,z then direction x,y,z, COORD_WIDTH each, zero padded to bytes
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // want_far
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // point x,y,z, COORD_WIDTH each, zero padded to bytes
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // hit_count[1:0], point_saturated[2]
  output logic [2:0] m_tuser,
  input  logic cfg_we,
  input  logic [rsi_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_wdata
);

  localparam int W   = COORD_WIDTH;
  localparam int ODW = ((3*W+7)/8)*8;
  localparam int RW  = W-1;          // radius
  localparam int CO  = W+1;          // origin minus center
  localparam int AW  = 2*W+1;        // a = |D|^2
  localparam int HW  = 2*W+2;        // h, signed
  localparam int CCW = 2*W+3;        // c, signed
  localparam int MW  = 2*W+2;        // magnitude operand for split multiplies
  localparam int LO  = W+2;
  localparam int HI  = MW-LO;
  localparam int XW  = 2*MW;         // full product width
  localparam int DXW = XW+1;         // discriminant, signed
  localparam int SW  = MW;           // root bits
  localparam int DM  = XW;
  localparam int NW  = 2*W+4;        // n, signed
  localparam int NM  = NW-1;
  localparam int NLO = W+2;
  localparam int NHI = NM-NLO;
  localparam int PM  = W+NM;         // |D*n|
  localparam int QW  = PM;           // quotient bits
  localparam int RMW = AW+1;
  localparam int SUW = QW+2;

  localparam logic [SUW-1:0] SMAX = {{(SUW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SUW-1:0] SMIN = {{(SUW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0] o;
    logic [2:0][W-1:0] d;
    logic              far;
  } fr_t;

  typedef struct packed {
    logic              anz;
    logic              hneg;
    logic              hzero;
    logic              cneg;
    logic              czero;
  } sgn_t;

  typedef struct packed {
    logic [2:0][W-1:0] o;
    logic [2:0][W-1:0] d;
    logic [AW-1:0]     a;
    logic [HW-1:0]     h;
    logic [1:0]        hits;
    logic              neg_s;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][W-1:0] o;
    logic [2:0][W-1:0] d;
    logic [AW-1:0]     a;
    logic [1:0]        hits;
  } bk_t;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------------------------------------------------------- config
  logic [W-1:0]  cx, cy, cz;
  logic [RW-1:0] rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      cz  <= '0;
      rad <= RW'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_addr)
        rsi_pkg::REG_CENTER_X: cx  <= cfg_wdata;
        rsi_pkg::REG_CENTER_Y: cy  <= cfg_wdata;
        rsi_pkg::REG_CENTER_Z: cz  <= cfg_wdata;
        rsi_pkg::REG_RADIUS:   rad <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- setup stages
  // p1: capture, CO = O - C
  // p2: squares and dot terms
  // p3: a, h, c
  // p4: magnitudes and sign flags
  // p5: partial products of h^2 and a*|c|
  // p6: h^2 and a*|c| assembled
  // p7: disc = h^2 - a*c
  logic            p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v;
  fr_t             p1_f, p2_f, p3_f, p4_f, p5_f, p6_f, p7_f;
  logic signed [CO-1:0]    p1_co [3];
  logic [2*W-1:0]          p2_dd [3];
  logic signed [2*W+1:0]   p2_cc [3];
  logic signed [2*W:0]     p2_cd [3];
  logic [2*RW-1:0]         p2_rr;
  logic [AW-1:0]           p3_a, p4_a, p5_a, p6_a, p7_a;
  logic signed [HW-1:0]    p3_h, p4_h, p5_h, p6_h, p7_h;
  logic signed [CCW-1:0]   p3_c;
  logic [MW-1:0]           p4_hm, p4_cm, p4_am;
  sgn_t                    p4_s, p5_s, p6_s, p7_s;
  logic [2*LO-1:0]         p5_hll, p5_all;
  logic [LO+HI-1:0]        p5_hlh, p5_alh, p5_ahl;
  logic [2*HI-1:0]         p5_hhh, p5_ahh;
  logic [XW-1:0]           p6_h2, p6_ac;
  logic signed [DXW-1:0]   p7_disc;
  logic [W-1:0]            cen [3];

  assign cen[0] = cx;
  assign cen[1] = cy;
  assign cen[2] = cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0;
      p5_v <= 1'b0; p6_v <= 1'b0; p7_v <= 1'b0;
    end else if (en) begin
      p1_v <= s_tvalid; p2_v <= p1_v; p3_v <= p2_v; p4_v <= p3_v;
      p5_v <= p4_v; p6_v <= p5_v; p7_v <= p6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1_f.o[k] <= s_tdata[k*W +: W];
        p1_f.d[k] <= s_tdata[(3+k)*W +: W];
        p1_co[k]  <= $signed({s_tdata[k*W+W-1], s_tdata[k*W +: W]})
                   - $signed({cen[k][W-1], cen[k]});
      end
      p1_f.far <= s_tuser;

      p2_f <= p1_f;
      for (int k = 0; k < 3; k++) begin
        p2_dd[k] <= (2*W)'($signed(p1_f.d[k]) * $signed(p1_f.d[k]));
        p2_cc[k] <= p1_co[k] * p1_co[k];
        p2_cd[k] <= p1_co[k] * $signed(p1_f.d[k]);
      end
      p2_rr <= rad * rad;

      p3_f <= p2_f;
      p3_a <= AW'(p2_dd[0]) + AW'(p2_dd[1]) + AW'(p2_dd[2]);
      p3_h <= HW'(p2_cd[0]) + HW'(p2_cd[1]) + HW'(p2_cd[2]);
      p3_c <= CCW'(p2_cc[0]) + CCW'(p2_cc[1]) + CCW'(p2_cc[2])
            - $signed({{(CCW-2*RW){1'b0}}, p2_rr});

      p4_f  <= p3_f;
      p4_a  <= p3_a;
      p4_h  <= p3_h;
      p4_hm <= p3_h[HW-1] ? MW'(-p3_h) : MW'(p3_h);
      p4_cm <= p3_c[CCW-1] ? MW'(-p3_c) : MW'(p3_c);
      p4_am <= MW'(p3_a);
      p4_s.anz   <= (p3_a != '0);
      p4_s.hneg  <= p3_h[HW-1];
      p4_s.hzero <= (p3_h == '0);
      p4_s.cneg  <= p3_c[CCW-1];
      p4_s.czero <= (p3_c == '0);

      p5_f   <= p4_f;
      p5_a   <= p4_a;
      p5_h   <= p4_h;
      p5_s   <= p4_s;
      p5_hll <= p4_hm[LO-1:0] * p4_hm[LO-1:0];
      p5_hlh <= p4_hm[LO-1:0] * p4_hm[MW-1:LO];
      p5_hhh <= p4_hm[MW-1:LO] * p4_hm[MW-1:LO];
      p5_all <= p4_am[LO-1:0] * p4_cm[LO-1:0];
      p5_alh <= p4_am[LO-1:0] * p4_cm[MW-1:LO];
      p5_ahl <= p4_am[MW-1:LO] * p4_cm[LO-1:0];
      p5_ahh <= p4_am[MW-1:LO] * p4_cm[MW-1:LO];

      p6_f  <= p5_f;
      p6_a  <= p5_a;
      p6_h  <= p5_h;
      p6_s  <= p5_s;
      // cross term of the square counts twice
      p6_h2 <= XW'(p5_hll) + (XW'(p5_hlh) << (LO+1)) + (XW'(p5_hhh) << (2*LO));
      p6_ac <= XW'(p5_all) + ((XW'(p5_alh) + XW'(p5_ahl)) << LO)
             + (XW'(p5_ahh) << (2*LO));

      p7_f <= p6_f;
      p7_a <= p6_a;
      p7_h <= p6_h;
      p7_s <= p6_s;
      p7_disc <= p6_s.cneg ? $signed({1'b0, p6_h2} + {1'b0, p6_ac})
                           : $signed({1'b0, p6_h2} - {1'b0, p6_ac});
    end
  end

  // Root classification. Tangent needs h < 0; of two roots the smaller is
  // >= 0 when h <= 0 and c >= 0, the larger when h <= 0 or c <= 0.
  logic [1:0] hits0;
  logic       dneg, dzero;

  assign dneg  = p7_disc[DXW-1];
  assign dzero = (p7_disc == '0);

  always_comb begin
    hits0 = rsi_pkg::HIT_NONE;
    if (p7_s.anz) begin
      if (dzero) begin
        if (p7_s.hneg) hits0 = rsi_pkg::HIT_ONE;
      end else if (!dneg) begin
        if ((p7_s.hneg || p7_s.hzero) && !p7_s.cneg) begin
          hits0 = rsi_pkg::HIT_TWO;
        end else if (p7_s.hneg || p7_s.hzero || p7_s.cneg || p7_s.czero) begin
          hits0 = rsi_pkg::HIT_ONE;
        end
      end
    end
  end

  // ---------------------------------------------------------------- square root
  // One root bit per stage, remainder form: rem = disc - root^2.
  logic           sq_v    [0:SW];
  logic [DM-1:0]  sq_rem  [0:SW];
  logic [SW-1:0]  sq_root [0:SW];
  sq_side_t       sq_side [0:SW];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= p7_v;
    if (en) begin
      sq_rem[0]        <= dneg ? '0 : p7_disc[DM-1:0];
      sq_root[0]       <= '0;
      sq_side[0].o     <= p7_f.o;
      sq_side[0].d     <= p7_f.d;
      sq_side[0].a     <= p7_a;
      sq_side[0].h     <= p7_h;
      sq_side[0].hits  <= hits0;
      sq_side[0].neg_s <= (hits0 == rsi_pkg::HIT_TWO) && !p7_f.far;
    end
  end

  for (genvar i = 0; i < SW; i++) begin : g_sq
    localparam int K = SW-1-i;
    logic [DM-1:0] trial;
    assign trial = ({{(DM-SW){1'b0}}, sq_root[i]} << (K+1))
                 | ({{(DM-1){1'b0}}, 1'b1} << (2*K));
    always_ff @(posedge clk) begin
      if (rst) sq_v[i+1] <= 1'b0;
      else if (en) sq_v[i+1] <= sq_v[i];
      if (en) begin
        sq_side[i+1] <= sq_side[i];
        if (sq_rem[i] >= trial) begin
          sq_rem[i+1]  <= sq_rem[i] - trial;
          sq_root[i+1] <= sq_root[i] | (SW'(1) << K);
        end else begin
          sq_rem[i+1]  <= sq_rem[i];
          sq_root[i+1] <= sq_root[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- n * D
  logic                 n_v, nm_v, pt_v;
  bk_t                  n_b, nm_b, pt_b;
  logic signed [NW-1:0] n_val;
  logic [NM-1:0]        nm_n;
  logic                 nm_nneg;
  logic [W-1:0]         nm_dm [3];
  logic                 nm_dneg [3];
  logic [W+NLO-1:0]     pt_pl [3];
  logic [W+NHI-1:0]     pt_ph [3];
  logic [2:0]           pt_sg;
  logic signed [NW-1:0] s_ext, h_ext;

  assign s_ext = $signed({{(NW-SW){1'b0}}, sq_root[SW]});
  assign h_ext = NW'($signed(sq_side[SW].h));

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0; nm_v <= 1'b0; pt_v <= 1'b0;
    end else if (en) begin
      n_v <= sq_v[SW]; nm_v <= n_v; pt_v <= nm_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_b.o    <= sq_side[SW].o;
      n_b.d    <= sq_side[SW].d;
      n_b.a    <= sq_side[SW].a;
      n_b.hits <= sq_side[SW].hits;
      n_val    <= sq_side[SW].neg_s ? (-h_ext - s_ext) : (-h_ext + s_ext);

      nm_b    <= n_b;
      nm_n    <= n_val[NW-1] ? NM'(-n_val) : NM'(n_val);
      nm_nneg <= n_val[NW-1];
      for (int k = 0; k < 3; k++) begin
        nm_dm[k]   <= n_b.d[k][W-1] ? -n_b.d[k] : n_b.d[k];
        nm_dneg[k] <= n_b.d[k][W-1];
      end

      pt_b <= nm_b;
      for (int k = 0; k < 3; k++) begin
        pt_pl[k] <= nm_dm[k] * nm_n[NLO-1:0];
        pt_ph[k] <= nm_dm[k] * nm_n[NM-1:NLO];
        pt_sg[k] <= nm_dneg[k] ^ nm_nneg;
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  // Three restoring dividers side by side, one quotient bit per stage.
  logic                    dv_v   [0:QW];
  bk_t                     dv_b   [0:QW];
  logic [2:0]              dv_sg  [0:QW];
  logic [2:0][PM-1:0]      dv_num [0:QW];
  logic [2:0][RMW-1:0]     dv_rem [0:QW];
  logic [2:0][QW-1:0]      dv_q   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= pt_v;
    if (en) begin
      dv_b[0]  <= pt_b;
      dv_sg[0] <= pt_sg;
      dv_rem[0] <= '0;
      dv_q[0]   <= '0;
      for (int k = 0; k < 3; k++) begin
        dv_num[0][k] <= PM'(pt_pl[k]) + (PM'(pt_ph[k]) << NLO);
      end
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_dv
    localparam int K = QW-1-i;
    logic [2:0][RMW-1:0] remn;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        remn[k] = {dv_rem[i][k][RMW-2:0], dv_num[i][k][K]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[i+1] <= 1'b0;
      else if (en) dv_v[i+1] <= dv_v[i];
      if (en) begin
        dv_b[i+1]   <= dv_b[i];
        dv_sg[i+1]  <= dv_sg[i];
        dv_num[i+1] <= dv_num[i];
        for (int k = 0; k < 3; k++) begin
          if (remn[k] >= RMW'(dv_b[i].a)) begin
            dv_rem[i+1][k] <= remn[k] - RMW'(dv_b[i].a);
            dv_q[i+1][k]   <= dv_q[i][k] | (QW'(1) << K);
          end else begin
            dv_rem[i+1][k] <= remn[k];
            dv_q[i+1][k]   <= dv_q[i][k];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- round, add, clamp
  logic              rd_v, su_v;
  bk_t               rd_b, su_b;
  logic [2:0]        rd_sg;
  logic [QW:0]       rd_q [3];
  logic [SUW-1:0]    su [3];
  logic [W-1:0]      pt_out [3];
  logic [2:0]        sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0; su_v <= 1'b0;
    end else if (en) begin
      rd_v <= dv_v[QW]; su_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_b  <= dv_b[QW];
      rd_sg <= dv_sg[QW];
      for (int k = 0; k < 3; k++) begin
        // half way or more rounds away from zero
        rd_q[k] <= {1'b0, dv_q[QW][k]}
                 + (QW+1)'({dv_rem[QW][k][AW-1:0], 1'b0} >= {1'b0, dv_b[QW].a});
      end

      su_b <= rd_b;
      for (int k = 0; k < 3; k++) begin
        su[k] <= SUW'($signed(rd_b.o[k]))
               + (rd_sg[k] ? -SUW'(rd_q[k]) : SUW'(rd_q[k]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ($signed(su[k]) > $signed(SMAX)) begin
        pt_out[k] = SMAX[W-1:0];
        sat[k]    = 1'b1;
      end else if ($signed(su[k]) < $signed(SMIN)) begin
        pt_out[k] = SMIN[W-1:0];
        sat[k]    = 1'b1;
      end else begin
        pt_out[k] = su[k][W-1:0];
        sat[k]    = 1'b0;
      end
    end
  end

  // output register; a miss returns the direction unclamped
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= su_v;
    if (en) begin
      if (su_b.hits == rsi_pkg::HIT_NONE) begin
        m_tdata <= ODW'({su_b.d[2], su_b.d[1], su_b.d[0]});
        m_tuser <= {1'b0, rsi_pkg::HIT_NONE};
      end else begin
        m_tdata <= ODW'({pt_out[2], pt_out[1], pt_out[0]});
        m_tuser <= {|sat, su_b.hits};
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_sphere_intersect: streams rays through the
// stream ports and checks every result word against a wide-integer predictor.
// Depends on rsi_pkg and the ray_sphere_intersect RTL.
module testbench;

  localparam int W = rsi_pkg::COORD_WIDTH;
  localparam logic signed [W-1:0] ONE = 1 <<< rsi_pkg::FRAC_BITS;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam int DRAIN = 5 * W + 40;     // pipeline depth plus margin
  localparam int STALL_LIMIT = 4000;     // cycles without any accepted word

  // 256 bits hold every intermediate: disc stays below 2^140
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [W-1:0] ox, oy, oz, dx, dy, dz;
    logic far;
  } ray_t;

  typedef struct packed {
    logic [1:0] hits;
    logic signed [W-1:0] px, py, pz;
    logic sat;
  } hit_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [((6*W+7)/8)*8-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [((3*W+7)/8)*8-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_we = 0;
  logic [rsi_pkg::CFG_AW-1:0] cfg_addr = rsi_pkg::REG_CENTER_X;
  logic [W-1:0] cfg_wdata = '0;

  ray_sphere_intersect DUT (.*);

  initial forever #5 clk = ~clk;

  // shadow copy of the sphere registers
  logic signed [W-1:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
  logic [W-2:0] sph_r = ONE;

  ray_t ray_q[$];        // rays waiting to be sent
  hit_t hit_q[$];        // predicted results, oldest first
  int mismatches = 0;
  int n_rays = 0, n_out = 0, n_hit1 = 0, n_hit2 = 0, n_sat = 0;
  bit calm = 0;          // no idling on either side

  // integer square root, floor
  function automatic wide_t isqrt(wide_t v);
    wide_t r, cand;
    r = 0;
    for (int k = 79; k >= 0; k--) begin
      cand = r | (wide_t'(1) <<< k);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // o + round(d*n/a), ties away from zero, clamped to the coordinate range
  function automatic logic signed [W-1:0] on_ray(logic signed [W-1:0] o,
      logic signed [W-1:0] d, wide_t n, wide_t a, inout logic sat);
    wide_t prod, pm, q, rem, sum, o_w, d_w;
    wide_t lim;
    o_w = o;
    d_w = d;
    lim = wide_t'(1) <<< (W - 1);
    prod = d_w * n;
    pm = (prod < 0) ? -prod : prod;
    q = pm / a;
    rem = pm % a;
    if (2 * rem >= a) q = q + 1;
    if (prod < 0) q = -q;
    sum = o_w + q;
    if (sum > lim - 1) begin sat = 1; return CMAX; end
    if (sum < -lim) begin sat = 1; return CMIN; end
    return sum[W-1:0];
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t res;
    wide_t o[3], d[3], co[3];
    wide_t a, h, c, disc, s, n, rad;
    logic sat;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    co[0] = o[0] - wide_t'(sph_cx);
    co[1] = o[1] - wide_t'(sph_cy);
    co[2] = o[2] - wide_t'(sph_cz);
    a = 0; h = 0; c = 0; n = 0; sat = 0;
    for (int k = 0; k < 3; k++) begin
      a += d[k] * d[k];
      c += co[k] * co[k];
      h += co[k] * d[k];
    end
    rad = $signed({1'b0, sph_r});
    c -= rad * rad;
    res.hits = rsi_pkg::HIT_NONE;
    if (a != 0) begin
      disc = h * h - a * c;
      if (disc == 0) begin
        // tangent: counts only strictly ahead of the origin
        if (h < 0) begin res.hits = rsi_pkg::HIT_ONE; n = -h; end
      end else if (disc > 0) begin
        s = isqrt(disc);
        if (h <= 0 && c >= 0) begin
          res.hits = rsi_pkg::HIT_TWO;
          n = r.far ? -h + s : -h - s;
        end else if (h <= 0 || c <= 0) begin
          res.hits = rsi_pkg::HIT_ONE;
          n = -h + s;
        end
      end
    end
    if (res.hits == rsi_pkg::HIT_NONE) begin
      res.px = r.dx; res.py = r.dy; res.pz = r.dz; res.sat = 0;
    end else begin
      res.px = on_ray(r.ox, r.dx, n, a, sat);
      res.py = on_ray(r.oy, r.dy, n, a, sat);
      res.pz = on_ray(r.oz, r.dz, n, a, sat);
      res.sat = sat;
    end
    return res;
  endfunction

  // ---------------- driver ----------------
  ray_t cur_ray;
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        hit_q.push_back(trace_ray(cur_ray));
        n_rays++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 0;
        end else if (ray_q.size() > 0) begin
          cur_ray = ray_q.pop_front();
          s_tdata <= {cur_ray.dz, cur_ray.dy, cur_ray.dx,
                      cur_ray.oz, cur_ray.oy, cur_ray.ox};
          s_tuser <= cur_ray.far;
          s_tvalid <= 1;
          // occasional idle burst before the next word
          if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int snk_gap = 0;
  always @(posedge clk) begin
    hit_t got, want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.hits = m_tuser[1:0];
        got.sat = m_tuser[2];
        got.px = m_tdata[W-1:0];
        got.py = m_tdata[2*W-1:W];
        got.pz = m_tdata[3*W-1:2*W];
        n_out++;
        if (hit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: hits=%0d", got.hits);
        end else begin
          want = hit_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word %0d: exp hits=%0d p=(%h %h %h) sat=%b",
                        " got hits=%0d p=(%h %h %h) sat=%b"},
                       n_out, want.hits, want.px, want.py, want.pz, want.sat,
                       got.hits, got.px, got.py, got.pz, got.sat);
          end else begin
            if (want.hits == rsi_pkg::HIT_ONE) n_hit1++;
            if (want.hits == rsi_pkg::HIT_TWO) n_hit2++;
            if (want.sat) n_sat++;
          end
        end
      end
      // receiver stalls in bursts
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 5);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (ray_q.size() == 0 && hit_q.size() == 0 && !s_tvalid))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", hit_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic set_reg(logic [rsi_pkg::CFG_AW-1:0] idx, logic [W-1:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      rsi_pkg::REG_CENTER_X: sph_cx = v;
      rsi_pkg::REG_CENTER_Y: sph_cy = v;
      rsi_pkg::REG_CENTER_Z: sph_cz = v;
      rsi_pkg::REG_RADIUS:   sph_r = v[W-2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_sphere(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z,
                            logic [W-1:0] r);
    set_reg(rsi_pkg::REG_CENTER_X, x);
    set_reg(rsi_pkg::REG_CENTER_Y, y);
    set_reg(rsi_pkg::REG_CENTER_Z, z);
    set_reg(rsi_pkg::REG_RADIUS, r);
  endtask

  // sender holds off until every result is back
  task automatic drain();
    wait (ray_q.size() == 0 && !s_tvalid && hit_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz, bit far);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz; r.far = far;
    ray_q.push_back(r);
  endtask

  function automatic logic signed [W-1:0] near_coord(logic signed [W-1:0] ctr, int span);
    longint off;
    off = longint'($urandom_range(0, 2 * span)) - span;
    return ctr + off[W-1:0];
  endfunction

  // mostly rays aimed around the sphere, some fully random
  task automatic add_random(int cnt);
    ray_t r;
    int span, sel;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(0, 99);
      span = (sph_r == 0 || sph_r > 32'h0800_0000) ? 32'h0004_0000 : 4 * sph_r;
      if (sel < 15) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
      end else begin
        r.ox = near_coord(sph_cx, span);
        r.oy = near_coord(sph_cy, span);
        r.oz = near_coord(sph_cz, span);
        if (sel < 85) begin
          // aim roughly at the center, with jitter
          r.dx = (sph_cx - r.ox) + near_coord(0, span / 4);
          r.dy = (sph_cy - r.oy) + near_coord(0, span / 4);
          r.dz = (sph_cz - r.oz) + near_coord(0, span / 4);
        end else begin
          r.dx = $urandom_range(0, 1) ? $urandom : near_coord(0, 4 * ONE);
          r.dy = $urandom_range(0, 1) ? $urandom : near_coord(0, 4 * ONE);
          r.dz = near_coord(0, 4 * ONE);
        end
        r.far = $urandom_range(0, 1);
      end
      ray_q.push_back(r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed rays against the reset sphere: unit radius at the origin
    add_ray(-3 * ONE, 0, 0, ONE, 0, 0, 1);          // two hits, far
    add_ray(-3 * ONE, 0, 0, ONE, 0, 0, 0);          // two hits, near
    add_ray(0, 0, 0, 0, ONE, 0, 1);                 // origin inside
    add_ray(-2 * ONE, ONE, 0, ONE, 0, 0, 0);        // tangent ahead
    add_ray(2 * ONE, ONE, 0, ONE, 0, 0, 0);         // tangent behind
    add_ray(3 * ONE, 0, 0, ONE, 0, 0, 1);           // sphere behind origin
    add_ray(-3 * ONE, 0, 0, 0, 0, 0, 1);            // zero direction
    add_ray(-3 * ONE, 5 * ONE, 0, ONE, 0, 0, 0);    // passes beside
    add_ray(ONE, 0, 0, ONE, 0, 0, 1);               // on surface, leaving
    add_ray(ONE, 0, 0, -ONE, 0, 0, 0);              // on surface, entering
    add_ray(ONE, 0, 0, -ONE, 0, 0, 1);
    add_ray(-3 * ONE, 0, 0, ONE, CMAX, 0, 1);       // steep direction, misses the sphere
    add_ray(-3 * ONE, 0, 0, 7, 3, 0, 1);            // tiny direction, misses the sphere
    add_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1);
    add_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
    add_ray(CMIN, 0, CMAX, CMAX, 0, CMIN, 1);
    add_ray(-1, -1, -1, -1, -1, -1, 0);
    drain();

    // extreme spheres
    set_sphere(CMAX, CMAX, CMAX, 32'hFFFF_FFFF);
    add_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1);
    add_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
    add_ray(CMAX, CMAX, CMAX, CMIN, 0, 0, 1);
    add_random(40);
    drain();
    set_sphere(CMIN, CMIN, CMIN, 0);
    add_ray(CMIN, CMIN, CMIN, ONE, 0, 0, 1);        // zero radius, origin at center
    add_ray(CMIN + ONE, CMIN, CMIN, -ONE, 0, 0, 0); // zero radius, tangent ahead
    add_random(40);
    drain();

    // ordinary spheres at random places
    for (int p = 0; p < 6; p++) begin
      set_sphere($urandom_range(0, 1) ? $urandom : near_coord(0, 64 * ONE),
                 near_coord(0, 64 * ONE), $urandom,
                 $urandom_range(0, 1) ? $urandom_range(1, 16 * ONE) : $urandom);
      add_random(100);
      drain();
    end

    // last part without idling
    set_sphere(near_coord(0, 8 * ONE), near_coord(0, 8 * ONE), near_coord(0, 8 * ONE),
               $urandom_range(ONE / 2, 4 * ONE));
    calm = 1;
    add_random(150);
    drain();
    repeat (DRAIN) @(posedge clk);

    $display("%0d rays sent, %0d results: %0d single hits, %0d double hits, %0d clamped",
             n_rays, n_out, n_hit1, n_hit2, n_sat);
    $display("sphere settings covered reset, extreme corners, zero and full radius");
    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, hit_q.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
